// ===== design/cmg_pkg.sv =====
// ----------------------------------------------------------------------------
// cmg_pkg
// Shared types, constants and helpers of the cylinder mesh generator.
// ----------------------------------------------------------------------------
package cmg_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_DIV       = 4095;
    localparam int CORDIC_STAGES = 18;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIVIDEND_W    = 44;
    localparam int DIV_STAGES    = DIVIDEND_W / DIV_STEP_BITS;
    localparam int QDEPTH        = 32;
    localparam int QADDR_W       = $clog2(QDEPTH);
    localparam int CNT_W         = $clog2(QDEPTH + 1);
    localparam int IDX_W         = 14;
    localparam logic signed [32:0] CK_GAIN_Q30 = 33'sd652032874;

    typedef enum logic [1:0] {
        KIND_VTX = 2'd0,
        KIND_TRI = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_CX  = 3'd0,
        REG_CY  = 3'd1,
        REG_CZ  = 3'd2,
        REG_RAD = 3'd3,
        REG_HGT = 3'd4,
        REG_DIV = 3'd5,
        REG_TOP = 3'd6,
        REG_BOT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [30:0] rad;
        logic        [30:0] hgt;
        logic        [11:0] div;
        logic               top;
        logic               bot;
    } cfg_t;

    typedef struct packed {
        logic        [11:0] step;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
    } vtx_t;

    function automatic logic [11:0] eff_div(input logic [11:0] div);
        logic [11:0] d;
        d = (div == 12'd0) ? 12'd1 : div;
        if (32'(d) > MAX_DIV)
            d = 12'(MAX_DIV);
        return d;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/cmg_div.sv =====
// ----------------------------------------------------------------------------
// cmg_div
// Pipelined restoring divider: phase = round(step * 2^32 / divisions).
// ----------------------------------------------------------------------------
module cmg_div
    import cmg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic [11:0] step_in,
    input  logic [11:0] div,
    output logic        valid_out,
    output logic [11:0] step_out,
    output logic [31:0] phase_out
);

    typedef struct packed {
        logic                  v;
        logic [11:0]           step;
        logic [11:0]           rem;
        logic [DIVIDEND_W-1:0] dend;
        logic [31:0]           q;
    } div_st_t;

    div_st_t stage_reg [DIV_STAGES+1];
    div_st_t stage_next [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg[0].v <= 1'b0;
        end
        else
        begin
            stage_reg[0].v    <= valid_in;
            stage_reg[0].step <= step_in;
            stage_reg[0].rem  <= 12'd0;
            stage_reg[0].dend <= {step_in, 32'd0} | DIVIDEND_W'(div[11:1]);
            stage_reg[0].q    <= 32'd0;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        always_comb
        begin
            logic [12:0]           r;
            logic [DIVIDEND_W-1:0] d;
            logic [31:0]           q;
            logic                  qb;
            r = {1'b0, stage_reg[k].rem};
            d = stage_reg[k].dend;
            q = stage_reg[k].q;
            for (int j = 0; j < DIV_STEP_BITS; j++)
            begin
                r  = {r[11:0], d[DIVIDEND_W-1]};
                d  = {d[DIVIDEND_W-2:0], 1'b0};
                qb = (r >= {1'b0, div});
                if (qb)
                    r = r - {1'b0, div};
                q = {q[30:0], qb};
            end
            stage_next[k].v    = stage_reg[k].v;
            stage_next[k].step = stage_reg[k].step;
            stage_next[k].rem  = r[11:0];
            stage_next[k].dend = d;
            stage_next[k].q    = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_reg[k+1].v <= 1'b0;
            else
                stage_reg[k+1] <= stage_next[k];
        end
    end

    assign valid_out = stage_reg[DIV_STAGES].v;
    assign step_out  = stage_reg[DIV_STAGES].step;
    assign phase_out = stage_reg[DIV_STAGES].q;

endmodule

// ===== design/cmg_cordic.sv =====
// ----------------------------------------------------------------------------
// cmg_cordic
// Pipelined rotation CORDIC, quadrant fold, radius scale and centre offset.
// ----------------------------------------------------------------------------
module cmg_cordic
    import cmg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic [11:0] step_in,
    input  logic [31:0] phase_in,
    input  cfg_t        cfg,
    output logic        valid_out,
    output vtx_t        vtx_out
);

    typedef struct packed {
        logic               v;
        logic [11:0]        step;
        logic [1:0]         q;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } cor_st_t;

    cor_st_t cst_reg [CORDIC_STAGES+1];
    cor_st_t cst_next [CORDIC_STAGES];

    logic               m_v_reg;
    logic [11:0]        m_step_reg;
    logic signed [31:0] m_co_reg, m_si_reg;
    logic               p_v_reg;
    logic [11:0]        p_step_reg;
    logic signed [63:0] p_c_reg, p_s_reg;
    logic               o_v_reg;
    vtx_t               o_reg;

    logic signed [31:0] co_next, si_next;
    logic signed [31:0] rad_s;
    logic signed [63:0] tc, ts;
    logic signed [34:0] sx, sy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg[0].v <= 1'b0;
        end
        else
        begin
            cst_reg[0].v    <= valid_in;
            cst_reg[0].step <= step_in;
            cst_reg[0].q    <= phase_in[31:30];
            cst_reg[0].x    <= CK_GAIN_Q30;
            cst_reg[0].y    <= 33'sd0;
            cst_reg[0].z    <= $signed({3'b000, phase_in[29:0]});
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        localparam logic signed [32:0] ATAN = $signed({1'b0, atan_turn(i)});
        always_comb
        begin
            cst_next[i] = cst_reg[i];
            if (!cst_reg[i].z[32])
            begin
                cst_next[i].x = cst_reg[i].x - (cst_reg[i].y >>> i);
                cst_next[i].y = cst_reg[i].y + (cst_reg[i].x >>> i);
                cst_next[i].z = cst_reg[i].z - ATAN;
            end
            else
            begin
                cst_next[i].x = cst_reg[i].x + (cst_reg[i].y >>> i);
                cst_next[i].y = cst_reg[i].y - (cst_reg[i].x >>> i);
                cst_next[i].z = cst_reg[i].z + ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cst_reg[i+1].v <= 1'b0;
            else
                cst_reg[i+1] <= cst_next[i];
        end
    end

    always_comb
    begin
        logic signed [32:0] x, y, nx, ny;
        x  = cst_reg[CORDIC_STAGES].x;
        y  = cst_reg[CORDIC_STAGES].y;
        nx = -x;
        ny = -y;
        case (cst_reg[CORDIC_STAGES].q)
            2'd0:    begin co_next = x[31:0];  si_next = y[31:0];  end
            2'd1:    begin co_next = ny[31:0]; si_next = x[31:0];  end
            2'd2:    begin co_next = nx[31:0]; si_next = ny[31:0]; end
            default: begin co_next = y[31:0];  si_next = nx[31:0]; end
        endcase
    end

    assign rad_s = $signed({1'b0, cfg.rad});
    assign tc    = (p_c_reg + 64'sd536870912) >>> 30;
    assign ts    = (p_s_reg + 64'sd536870912) >>> 30;
    assign sx    = {tc[33], tc[33:0]} + {{3{cfg.cx[31]}}, cfg.cx};
    assign sy    = {ts[33], ts[33:0]} + {{3{cfg.cy[31]}}, cfg.cy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            m_v_reg    <= cst_reg[CORDIC_STAGES].v;
            m_step_reg <= cst_reg[CORDIC_STAGES].step;
            m_co_reg   <= co_next;
            m_si_reg   <= si_next;
            p_v_reg    <= m_v_reg;
            p_step_reg <= m_step_reg;
            p_c_reg    <= rad_s * m_co_reg;
            p_s_reg    <= rad_s * m_si_reg;
            o_v_reg    <= p_v_reg;
            o_reg.step <= p_step_reg;
            o_reg.rx   <= sat32(sx);
            o_reg.ry   <= sat32(sy);
        end
    end

    assign valid_out = o_v_reg;
    assign vtx_out   = o_reg;

endmodule

// ===== design/cmg_emit.sv =====
// ----------------------------------------------------------------------------
// cmg_emit
// Ring vertex queue and serializer that streams the results of each step.
// ----------------------------------------------------------------------------
module cmg_emit
    import cmg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  vtx_t               vtx_in,
    input  cfg_t               cfg,
    output logic               pop,
    output logic               done,
    output logic [1:0]         item_kind,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [IDX_W-1:0]   corner_a,
    output logic [IDX_W-1:0]   corner_b,
    output logic [IDX_W-1:0]   corner_c,
    output logic               last_of_step
);

    vtx_t               mem [QDEPTH];
    logic [QADDR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               active_reg, active_next;
    logic [7:0]         mask_reg, mask_next;

    logic               done_reg;
    kind_t              kind_reg, kind_next;
    logic signed [31:0] px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic [IDX_W-1:0]   ca_reg, cb_reg, cc_reg, ca_next, cb_next, cc_next;
    logic               last_reg, last_next;

    vtx_t               head;
    logic               go, err, lt;
    logic [11:0]        div_e;
    logic [7:0]         full, cur, low, rest;
    logic [2:0]         slot;
    logic [IDX_W-1:0]   a, b, c, d, bc;
    logic signed [31:0] z_top, z_bot;
    logic signed [34:0] half;

    assign head  = mem[rp_reg];
    assign go    = (cnt_reg != '0);
    assign div_e = eff_div(cfg.div);
    assign err   = head.step > div_e;
    assign lt    = head.step < div_e;

    assign full = {lt & cfg.bot, lt & cfg.top, lt, lt, 2'b11,
                   (head.step == 12'd0) & cfg.bot, (head.step == 12'd0) & cfg.top};
    assign cur  = err ? 8'd1 : (active_reg ? mask_reg : full);
    assign low  = cur & (~cur + 8'd1);
    assign rest = cur & ~low;
    assign pop  = go && (rest == 8'd0);

    always_comb
    begin
        slot = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (cur[k])
                slot = 3'(k);
        end
    end

    assign half  = {5'b00000, cfg.hgt[30:1]};
    assign z_top = sat32({{3{cfg.cz[31]}}, cfg.cz} + half);
    assign z_bot = sat32({{3{cfg.cz[31]}}, cfg.cz} - half);
    assign a     = IDX_W'(cfg.top) + IDX_W'(cfg.bot) + {1'b0, head.step, 1'b0};
    assign b     = a + IDX_W'(1);
    assign c     = a + IDX_W'(2);
    assign d     = a + IDX_W'(3);
    assign bc    = IDX_W'(cfg.top);

    always_comb
    begin
        kind_next = KIND_VTX;
        px_next   = '0;
        py_next   = '0;
        pz_next   = '0;
        ca_next   = '0;
        cb_next   = '0;
        cc_next   = '0;
        last_next = (rest == 8'd0);
        if (err)
        begin
            kind_next = KIND_ERR;
        end
        else
        begin
            case (slot)
                3'd0:
                begin
                    px_next = cfg.cx; py_next = cfg.cy; pz_next = z_top;
                end
                3'd1:
                begin
                    px_next = cfg.cx; py_next = cfg.cy; pz_next = z_bot;
                end
                3'd2:
                begin
                    px_next = head.rx; py_next = head.ry; pz_next = z_top;
                end
                3'd3:
                begin
                    px_next = head.rx; py_next = head.ry; pz_next = z_bot;
                end
                3'd4:
                begin
                    kind_next = KIND_TRI; ca_next = a; cb_next = b; cc_next = c;
                end
                3'd5:
                begin
                    kind_next = KIND_TRI; ca_next = b; cb_next = d; cc_next = c;
                end
                3'd6:
                begin
                    kind_next = KIND_TRI; ca_next = '0; cb_next = a; cc_next = c;
                end
                default:
                begin
                    kind_next = KIND_TRI; ca_next = bc; cb_next = d; cc_next = b;
                end
            endcase
        end
    end

    always_comb
    begin
        active_next = active_reg;
        mask_next   = mask_reg;
        if (go)
        begin
            active_next = (rest != 8'd0);
            mask_next   = rest;
        end
        cnt_next = cnt_reg + CNT_W'(valid_in) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
            mem[wp_reg] <= vtx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            mask_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (valid_in)
                wp_reg <= wp_reg + QADDR_W'(1);
            if (pop)
                rp_reg <= rp_reg + QADDR_W'(1);
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            mask_reg   <= mask_next;
            done_reg   <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        cc_reg   <= cc_next;
        last_reg <= last_next;
    end

    assign done         = done_reg;
    assign item_kind    = kind_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign pos_z        = pz_reg;
    assign corner_a     = ca_reg;
    assign corner_b     = cb_reg;
    assign corner_c     = cc_reg;
    assign last_of_step = last_reg;

endmodule

// ===== design/cylinder_mesh_generator.sv =====
// ----------------------------------------------------------------------------
// cylinder_mesh_generator
// Streams the vertices and triangles of a capped cylinder, one step at a time.
// ----------------------------------------------------------------------------
// A step index is taken when start is high and busy is low. Each step passes
// a divider (12 stages), a CORDIC (19 stages) and three scale stages, then
// waits in a 32-entry queue; its results leave one per cycle on done. A step
// makes 1 to 8 results, so the sustained rate of steps is set by the output
// port and the result count of each step. busy is high while 32 accepted
// steps still have their last result to put on the ports. Results cannot be
// held off.
module cylinder_mesh_generator
    import cmg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [11:0]        step_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic [1:0]         item_kind,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic [13:0]        corner_a,
    output logic [13:0]        corner_b,
    output logic [13:0]        corner_c,
    output logic               last_of_step
);

    cfg_t             cfg_reg;
    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             accept, pop;
    logic             dv, cv;
    logic [11:0]      dstep;
    logic [31:0]      phase;
    vtx_t             vtx;
    logic [11:0]      div_e;

    assign cfg_ready     = 1'b1;
    assign busy          = (inflight_reg == CNT_W'(QDEPTH));
    assign accept        = start && !busy;
    assign inflight_next = inflight_reg + CNT_W'(accept) - CNT_W'(pop);
    assign div_e         = eff_div(cfg_reg.div);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cx   <= '0;
            cfg_reg.cy   <= '0;
            cfg_reg.cz   <= '0;
            cfg_reg.rad  <= 31'(1 << (FRAC_BITS - 1));
            cfg_reg.hgt  <= 31'(1 << FRAC_BITS);
            cfg_reg.div  <= 12'd16;
            cfg_reg.top  <= 1'b1;
            cfg_reg.bot  <= 1'b1;
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CX:  cfg_reg.cx  <= cfg_data;
                    REG_CY:  cfg_reg.cy  <= cfg_data;
                    REG_CZ:  cfg_reg.cz  <= cfg_data;
                    REG_RAD: cfg_reg.rad <= cfg_data[30:0];
                    REG_HGT: cfg_reg.hgt <= cfg_data[30:0];
                    REG_DIV: cfg_reg.div <= cfg_data[11:0];
                    REG_TOP: cfg_reg.top <= cfg_data[0];
                    REG_BOT: cfg_reg.bot <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    cmg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .step_in   (step_index),
        .div       (div_e),
        .valid_out (dv),
        .step_out  (dstep),
        .phase_out (phase)
    );

    cmg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (dv),
        .step_in   (dstep),
        .phase_in  (phase),
        .cfg       (cfg_reg),
        .valid_out (cv),
        .vtx_out   (vtx)
    );

    cmg_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (cv),
        .vtx_in       (vtx),
        .cfg          (cfg_reg),
        .pop          (pop),
        .done         (done),
        .item_kind    (item_kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .last_of_step (last_of_step)
    );

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(QDEPTH))
        else $error("in-flight count above queue depth");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> inflight_reg != '0)
        else $error("queue pop with no item in flight");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && item_kind == KIND_ERR) |-> last_of_step)
        else $error("error result not last of its step");
`endif

endmodule

// ===== verif/cylinder_mesh_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_mesh_generator_test
// Drives step indices under several register settings, predicts the vertex
// and triangle stream of each step with an independent CORDIC model, and
// compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
module cylinder_mesh_generator_test;
    import cmg_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [13:0]        ca;
        logic [13:0]        cb;
        logic [13:0]        cc;
        logic               last;
    } mesh_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [11:0]        step_index = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               done;
    logic [1:0]         item_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [13:0]        corner_a;
    logic [13:0]        corner_b;
    logic [13:0]        corner_c;
    logic               last_of_step;

    cylinder_mesh_generator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .step_index(step_index), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
        .item_kind(item_kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .last_of_step(last_of_step)
    );

    always #1 clk = ~clk;

    logic signed [31:0] m_cx, m_cy, m_cz;
    logic [30:0]        m_rad, m_hgt;
    logic [11:0]        m_div;
    logic               m_top, m_bot;

    logic [11:0]  step_queue[$];
    mesh_item_t   mesh_expected[$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           idle_on = 1'b1;
    bit           hold_steps = 1'b0;
    int           gap = 0;
    logic         accepted_q = 1'b0;

    localparam longint ATAN_TBL [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0};

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic mesh_item_t make_vertex(longint x, longint y, longint z);
        mesh_item_t r;
        r = '0;
        r.kind = KIND_VTX;
        r.px = clamp32(x);
        r.py = clamp32(y);
        r.pz = clamp32(z);
        return r;
    endfunction

    function automatic mesh_item_t make_tri(int a, int b, int c);
        mesh_item_t r;
        r = '0;
        r.kind = KIND_TRI;
        r.ca = a[13:0];
        r.cb = b[13:0];
        r.cc = c[13:0];
        return r;
    endfunction

    task automatic predict_step(input logic [11:0] s);
        longint dv, ph, z, x, y, nx, co, si, half, rx, ry, cz;
        int q, i, st, a;
        mesh_item_t r;
        dv = m_div;
        if (dv == 0)
            dv = 1;
        if (dv > MAX_DIV)
            dv = MAX_DIV;
        if (s > dv)
        begin
            r = '0;
            r.kind = KIND_ERR;
            r.last = 1'b1;
            mesh_expected.push_back(r);
            return;
        end
        half = m_hgt >> 1;
        cz = m_cz;
        if (s == 0)
        begin
            if (m_top)
                mesh_expected.push_back(make_vertex(m_cx, m_cy, cz + half));
            if (m_bot)
                mesh_expected.push_back(make_vertex(m_cx, m_cy, cz - half));
        end
        ph = (((longint'(s)) << 32) + (dv >> 1)) / dv;
        ph = ph & 64'hFFFF_FFFF;
        q = int'((ph >> 30) & 3);
        z = ph & 64'h3FFF_FFFF;
        x = 652032874;
        y = 0;
        for (i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shr_arith(y, i);
                y = y + shr_arith(x, i);
                z = z - ATAN_TBL[i];
            end
            else
            begin
                nx = x + shr_arith(y, i);
                y = y - shr_arith(x, i);
                z = z + ATAN_TBL[i];
            end
            x = nx;
        end
        case (q)
            0: begin co = x;  si = y;  end
            1: begin co = -y; si = x;  end
            2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
        rx = m_cx + shr_arith(longint'(m_rad) * co + (64'sd1 << 29), 30);
        ry = m_cy + shr_arith(longint'(m_rad) * si + (64'sd1 << 29), 30);
        mesh_expected.push_back(make_vertex(rx, ry, cz + half));
        mesh_expected.push_back(make_vertex(rx, ry, cz - half));
        if (s < dv)
        begin
            st = m_top + m_bot;
            a = st + 2 * s;
            mesh_expected.push_back(make_tri(a, a + 1, a + 2));
            mesh_expected.push_back(make_tri(a + 1, a + 3, a + 2));
            if (m_top)
                mesh_expected.push_back(make_tri(0, a, a + 2));
            if (m_bot)
                mesh_expected.push_back(make_tri(m_top ? 1 : 0, a + 3, a + 1));
        end
        r = mesh_expected.pop_back();
        r.last = 1'b1;
        mesh_expected.push_back(r);
    endtask

    // driver: present queued steps, random idle bursts
    always @(negedge clk)
    begin
        if (!rst_n || cfg_valid)
            start <= 1'b0;
        else if (start && !accepted_q)
            ;
        else if (gap > 0)
        begin
            gap <= gap - 1;
            start <= 1'b0;
        end
        else if (step_queue.size() > 0 && !hold_steps)
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                gap <= $urandom_range(1, 6);
                start <= 1'b0;
            end
            else
            begin
                step_index <= step_queue.pop_front();
                start <= 1'b1;
            end
        end
        else
            start <= 1'b0;
    end

    // monitor: predict accepted steps, check results
    always @(posedge clk)
    begin
        mesh_item_t got, want;
        cycles <= cycles + 1;
        accepted_q <= 1'b0;
        if (rst_n && start && !busy)
        begin
            predict_step(step_index);
            accepted_q <= 1'b1;
        end
        if (rst_n && done)
        begin
            got = '{item_kind, pos_x, pos_y, pos_z, corner_a, corner_b,
                    corner_c, last_of_step};
            if (mesh_expected.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = mesh_expected.pop_front();
                if (got !== want)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CX:  m_cx = v;
            REG_CY:  m_cy = v;
            REG_CZ:  m_cz = v;
            REG_RAD: m_rad = v[30:0];
            REG_HGT: m_hgt = v[30:0];
            REG_DIV: m_div = v[11:0];
            REG_TOP: m_top = v[0];
            default: m_bot = v[0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        wait (step_queue.size() == 0);
        @(posedge clk);
        while (start || mesh_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_steps(input int n, input int dv);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                step_queue.push_back(12'($urandom));
            else
                step_queue.push_back(12'($urandom_range(0, dv + 1)));
        end
    endtask

    initial
    begin
        m_cx = 0; m_cy = 0; m_cz = 0;
        m_rad = 31'd32768; m_hgt = 31'd65536;
        m_div = 12'd16; m_top = 1'b1; m_bot = 1'b1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed steps at reset settings
        step_queue = '{0, 1, 4, 8, 12, 15, 16, 17, 12'hFFF, 0};
        drain_all();
        // extremes
        write_reg(REG_CX, 32'h7FFF_FFFF);
        write_reg(REG_CY, 32'h8000_0000);
        write_reg(REG_CZ, 32'h7FFF_0000);
        write_reg(REG_RAD, 32'h7FFF_FFFF);
        write_reg(REG_HGT, 32'h7FFF_FFFF);
        write_reg(REG_DIV, 32'd0);
        write_reg(REG_TOP, 32'd0);
        write_reg(REG_BOT, 32'd1);
        step_queue = '{0, 1, 2, 12'hFFF};
        drain_all();
        write_reg(REG_DIV, 32'd4095);
        write_reg(REG_BOT, 32'd0);
        step_queue = '{0, 4094, 4095, 4096 - 1, 2047, 1024};
        drain_all();
        write_reg(REG_DIV, 32'd4095);
        write_reg(REG_TOP, 32'd1);
        write_reg(REG_CX, 32'h8000_0000);
        write_reg(REG_CY, 32'h7FFF_FFFF);
        write_reg(REG_CZ, 32'h8000_0000);
        step_queue = '{0, 1000, 3000, 4095};
        drain_all();
        // random phases
        repeat (5)
        begin
            write_reg(REG_CX, $urandom);
            write_reg(REG_CY, $urandom);
            write_reg(REG_CZ, $urandom);
            write_reg(REG_RAD, $urandom);
            write_reg(REG_HGT, $urandom);
            write_reg(REG_DIV, $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom);
            write_reg(REG_TOP, $urandom);
            write_reg(REG_BOT, $urandom);
            push_steps(12, m_div == 0 ? 1 : m_div);
            hold_steps = 1'b0;
            wait (step_queue.size() < 6);
            hold_steps = 1'b1;
            while (mesh_expected.size() != 0)
                @(posedge clk);
            hold_steps = 1'b0;
            push_steps(12, m_div == 0 ? 1 : m_div);
            drain_all();
        end
        idle_on = 1'b0;
        write_reg(REG_DIV, 32'd9);
        write_reg(REG_RAD, 32'h0001_0000);
        push_steps(20, 9);
        drain_all();
        if (mismatches == 0)
            $display("PASS cylinder_mesh_generator");
        else
            $display("FAIL cylinder_mesh_generator");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > 200000)
        begin
            $display("FAIL cylinder_mesh_generator");
            $finish;
        end
    end

endmodule
